// ===== design/count_min_sketch_top_macros.svh =====
`ifndef COUNT_MIN_SKETCH_TOP_MACROS_SVH
`define COUNT_MIN_SKETCH_TOP_MACROS_SVH

// Property sampled on clk, off while in reset
`define CMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies consequence in the next
`define CMS_ASSERT_NEXT(lbl, pre, post, msg) \
  `CMS_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// ===== design/cms_pkg.sv =====
`default_nettype none
package cms_pkg;

  localparam int unsigned COLS     = 1024;
  localparam int unsigned ROWS     = 8;
  localparam int unsigned COL_W    = 10;
  localparam int unsigned ROW_W    = 3;
  localparam int unsigned ADDR_W   = ROW_W + COL_W;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned SUM_W    = 64;

  // Mersenne prime 2^31-1: modulo by folding
  localparam logic [31:0] PRIME_MODULUS = 32'h7FFF_FFFF;
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_UPDATE   = 2'd0;
  localparam opcode_t OP_ESTIMATE = 2'd1;
  localparam opcode_t OP_LOAD     = 2'd2;
  localparam opcode_t OP_NOP      = 2'd3;

  typedef logic cfg_idx_t;
  localparam cfg_idx_t CFG_WIDTH = 1'b0;
  localparam cfg_idx_t CFG_DEPTH = 1'b1;

endpackage
`default_nettype wire

// ===== design/count_min_sketch_top.sv =====
// Channel   Dir  tdata (low bit up)                                     tuser
// in_       in   item_key 32, increment 16, row_index 3, coef_mult 31,  opcode 2
//                coef_add 31, zero pad to 120
// out_      out  estimate_count 32, running_sum 64                      -
// cfg_      in   cfg_wen, cfg_index (0 width_in_use, 1 depth_in_use), cfg_wdata 11
//
// Update and estimate: each active row runs multiply, fold, a remainder by width
// (4 bits a cycle), counter read, then write (update) or minimum (estimate).
// Load and unknown opcodes skip the rows and go straight to the result.
// After reset the 8192-entry counter memory is cleared, one entry a cycle.
// One item at a time; in_tready is high only when the block is idle.
// A held result stalls the block in its done state; no new item is taken until it is released.
`default_nettype none
module count_min_sketch_top (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  // item_key, increment, row_index, coef_mult, coef_add, pad
  input  wire logic [119:0]            in_tdata,
  // opcode
  input  wire cms_pkg::opcode_t        in_tuser,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  // estimate_count, running_sum
  output logic [95:0]                  out_tdata,
  input  wire logic                    cfg_wen,
  input  wire cms_pkg::cfg_idx_t       cfg_index,
  input  wire logic [10:0]             cfg_wdata
);
  import cms_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MUL, S_FOLD, S_MOD, S_READ, S_CHECK, S_DONE
  } state_t;

  state_t            state_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [10:0]       width_r;
  logic [3:0]        depth_r;
  logic [10:0]       w_eff_r;
  logic [ROW_W-1:0]  row_last_r;
  logic [ROW_W-1:0]  row_r;
  opcode_t           op_r;
  logic [31:0]       key_r;
  logic [15:0]       inc_r;
  logic [62:0]       prod_r;
  logic [31:0]       hsh_r;
  logic [COL_W-1:0]  rem_r;
  logic [2:0]        mod_cnt_r;
  logic [CNT_W-1:0]  est_r;
  logic [SUM_W-1:0]  total_r;
  logic              out_tvalid_r;
  logic [95:0]       out_tdata_r;

  logic [30:0]       coef_a_r [ROWS];
  logic [30:0]       coef_b_r [ROWS];

  logic [CNT_W-1:0]  mem [2**ADDR_W];
  logic [CNT_W-1:0]  rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CNT_W-1:0]  mem_wdata;

  logic              in_acc;
  logic [31:0]       in_key;
  logic [15:0]       in_inc;
  logic [2:0]        in_row;
  logic [30:0]       in_mult;
  logic [30:0]       in_add;
  logic [10:0]       w_eff;
  logic [ROW_W-1:0]  row_last;
  logic [32:0]       fold_x;
  logic [31:0]       fold_y;
  logic [31:0]       hash_mod_p;
  logic [COL_W-1:0]  rem_nxt;
  logic [10:0]       trial;
  logic [32:0]       sat_sum;
  logic [CNT_W-1:0]  upd_val;

  assign in_key  = in_tdata[31:0];
  assign in_inc  = in_tdata[47:32];
  assign in_row  = in_tdata[50:48];
  assign in_mult = in_tdata[81:51];
  assign in_add  = in_tdata[112:82];

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    if (width_r == 11'd0) begin
      w_eff = 11'd1;
    end else if (width_r > 11'(COLS)) begin
      w_eff = 11'(COLS);
    end else begin
      w_eff = width_r;
    end
    if (depth_r == 4'd0) begin
      row_last = '0;
    end else if (depth_r > 4'(ROWS)) begin
      row_last = ROW_W'(ROWS - 1);
    end else begin
      row_last = ROW_W'(depth_r - 4'd1);
    end
  end

  always_comb begin
    fold_x = {2'b00, prod_r[30:0]} + {1'b0, prod_r[62:31]};
    fold_y = {1'b0, fold_x[30:0]} + {30'd0, fold_x[32:31]};
    hash_mod_p = (fold_y >= PRIME_MODULUS) ? fold_y - PRIME_MODULUS : fold_y;
  end

  always_comb begin
    rem_nxt = rem_r;
    trial   = '0;
    for (int k = 0; k < 4; k++) begin
      trial = {rem_nxt, hsh_r[31-k]};
      if (trial >= w_eff_r) begin
        trial = trial - w_eff_r;
      end
      rem_nxt = trial[COL_W-1:0];
    end
  end

  always_comb begin
    sat_sum = {1'b0, rd_data_r} + {17'd0, inc_r};
    upd_val = sat_sum[32] ? CNT_MAX : sat_sum[CNT_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = {row_r, rem_r};
    mem_wdata = upd_val;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (state_r == S_CHECK && op_r == OP_UPDATE) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[{row_r, rem_r}];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == OP_LOAD) begin
      coef_a_r[in_row] <= in_mult;
      coef_b_r[in_row] <= in_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      width_r      <= 11'(COLS);
      depth_r      <= 4'(ROWS);
      total_r      <= '0;
      out_tvalid_r <= 1'b0;
      row_r        <= '0;
      rem_r        <= '0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          CFG_WIDTH: width_r <= cfg_wdata;
          CFG_DEPTH: depth_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (state_r == S_DONE && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (&clr_cnt_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op_r       <= in_tuser;
            key_r      <= in_key;
            inc_r      <= in_inc;
            w_eff_r    <= w_eff;
            row_last_r <= row_last;
            row_r      <= '0;
            est_r      <= (in_tuser == OP_ESTIMATE) ? CNT_MAX : '0;
            if (in_tuser == OP_UPDATE) begin
              total_r <= total_r + {48'd0, in_inc};
            end
            if (in_tuser == OP_UPDATE || in_tuser == OP_ESTIMATE) begin
              state_r <= S_MUL;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_MUL: begin
          prod_r  <= {32'd0, coef_a_r[row_r]} * {31'd0, key_r} + {32'd0, coef_b_r[row_r]};
          state_r <= S_FOLD;
        end
        S_FOLD: begin
          hsh_r     <= {1'b0, hash_mod_p[30:0]};
          rem_r     <= '0;
          mod_cnt_r <= '0;
          state_r   <= S_MOD;
        end
        S_MOD: begin
          rem_r     <= rem_nxt;
          hsh_r     <= {hsh_r[27:0], 4'd0};
          mod_cnt_r <= mod_cnt_r + 1'b1;
          if (&mod_cnt_r) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (op_r == OP_ESTIMATE && rd_data_r < est_r) begin
            est_r <= rd_data_r;
          end
          if (row_r == row_last_r) begin
            state_r <= S_DONE;
          end else begin
            row_r   <= row_r + 1'b1;
            state_r <= S_MUL;
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {total_r, est_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`include "count_min_sketch_top_macros.svh"

  `CMS_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "second item taken while busy")
  `CMS_ASSERT_NEXT(a_total_add, in_tvalid && in_tready && in_tuser == OP_UPDATE, total_r == $past(total_r) + {48'd0, $past(in_tdata[47:32])}, "running total not advanced")
  `CMS_ASSERT_NEXT(a_done_hold, state_r == S_DONE && out_tvalid && !out_tready, state_r == S_DONE, "result overwritten while stalled")
  `CMS_ASSERT(a_clear_busy, state_r == S_CLEAR |-> !in_tready && !out_tvalid, "item activity during clear")

endmodule
`default_nettype wire
